// ----- hdl/utf8v_pkg.sv -----
// utf8v_pkg: byte range constants and the result type of the utf-8 stream validator
// used by utf8_stream_validator_unit; no dependencies
package utf8v_pkg;

    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD3_SUR = 8'hED;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] E0_LO     = 8'hA0;
    localparam logic [7:0] ED_HI     = 8'h9F;
    localparam logic [7:0] F0_LO     = 8'h90;
    localparam logic [7:0] F4_HI     = 8'h8F;

    localparam int OUT_FIELD_BITS = 66;
    localparam int OUT_TDATA_BITS = 72;

    typedef struct packed {
        logic [31:0] point_total;
        logic [31:0] bad_offset;
        logic        all_ascii;
        logic        text_valid;
    } result_t;

endpackage

// ----- hdl/utf8_stream_validator_unit.sv -----
// utf8_stream_validator_unit: strict utf-8 checker over a byte stream, one result per text
// depends on utf8v_pkg
//
//  channel | dir | tdata (low bit up)                                  | tlast
//  s_      | in  | data_byte[7:0]                                      | last_byte
//  m_      | out | text_valid, all_ascii, bad_offset[31:0],            | -
//          |     | point_total[31:0], zero pad to 72 bits              |
//
// one byte beat per clock sustained while results are drained; each byte is held in the input register and
// its text's result is registered into the output register when the last byte leaves the input register.
// aresetn is synchronous and clears the text state and both valid flags.
// a stalled result holds the output register; the input register keeps taking beats while it is
// empty, or while the output register is empty or being drained in the same cycle.
module utf8_stream_validator_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // data_byte
    input  logic                                s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // text_valid, all_ascii, bad_offset, point_total, zero pad
    output logic [utf8v_pkg::OUT_TDATA_BITS-1:0] m_tdata
);
    import utf8v_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [31:0] to32(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        to32 = wide[31:0];
    endfunction

    // input register
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_last_reg;
    logic            advance;

    // text state
    logic [COUNT_WIDTH-1:0] pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0] points_reg, points_next;
    logic [1:0]             expected_reg, expected_next;
    logic [7:0]             low_reg, low_next;
    logic [7:0]             high_reg, high_next;
    logic [COUNT_WIDTH-1:0] lead_pos_reg, lead_pos_next;
    logic                   pend_reg, pend_next;
    logic [COUNT_WIDTH-1:0] pend_pos_reg, pend_pos_next;
    logic                   err_reg, err_next;
    logic [COUNT_WIDTH-1:0] err_pos_reg, err_pos_next;
    logic                   non_ascii_reg, non_ascii_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic    cut_off;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        points_next    = points_reg;
        expected_next  = expected_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        lead_pos_next  = lead_pos_reg;
        pend_next      = pend_reg;
        pend_pos_next  = pend_pos_reg;
        err_next       = err_reg;
        err_pos_next   = err_pos_reg;
        non_ascii_next = non_ascii_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        cut_off        = 1'b0;

        if (advance) begin
            if (in_byte_reg > ASCII_MAX) begin
                non_ascii_next = 1'b1;
            end
            if (!err_reg) begin
                if (expected_reg == 2'd0) begin
                    priority if (in_byte_reg <= ASCII_MAX) begin
                        points_next = sat_inc(points_reg);
                    end else if (in_byte_reg >= LEAD2_LO && in_byte_reg <= LEAD2_HI) begin
                        expected_next = 2'd1;
                        low_next      = CONT_LO;
                        high_next     = CONT_HI;
                        lead_pos_next = pos_reg;
                        pend_next     = 1'b0;
                    end else if (in_byte_reg >= LEAD3_LO && in_byte_reg <= LEAD3_HI) begin
                        expected_next = 2'd2;
                        lead_pos_next = pos_reg;
                        pend_next     = 1'b0;
                        low_next      = (in_byte_reg == LEAD3_LO) ? E0_LO : CONT_LO;
                        high_next     = (in_byte_reg == LEAD3_SUR) ? ED_HI : CONT_HI;
                    end else if (in_byte_reg >= LEAD4_LO && in_byte_reg <= LEAD4_HI) begin
                        expected_next = 2'd3;
                        lead_pos_next = pos_reg;
                        pend_next     = 1'b0;
                        low_next      = (in_byte_reg == LEAD4_LO) ? F0_LO : CONT_LO;
                        high_next     = (in_byte_reg == LEAD4_HI) ? F4_HI : CONT_HI;
                    end else begin
                        err_next     = 1'b1;
                        err_pos_next = pos_reg;
                    end
                end else begin
                    // only the first bad continuation of a sequence is kept
                    if (!pend_reg && (in_byte_reg < low_reg || in_byte_reg > high_reg)) begin
                        pend_next     = 1'b1;
                        pend_pos_next = pos_reg;
                    end
                    low_next      = CONT_LO;
                    high_next     = CONT_HI;
                    expected_next = expected_reg - 2'd1;
                    if (expected_reg == 2'd1) begin
                        if (pend_next) begin
                            err_next     = 1'b1;
                            err_pos_next = pend_pos_next;
                            pend_next    = 1'b0;
                        end else begin
                            points_next = sat_inc(points_reg);
                        end
                    end
                end
            end
            pos_next = sat_inc(pos_reg);

            if (in_last_reg) begin
                // a sequence cut off by the end of text blames its lead byte
                cut_off              = !err_next && (expected_next != 2'd0);
                out_valid_next       = 1'b1;
                out_next.text_valid  = !(err_next || cut_off);
                out_next.all_ascii   = !non_ascii_next;
                out_next.bad_offset  = err_next ? to32(err_pos_next) :
                                       (cut_off ? to32(lead_pos_next) : 32'd0);
                out_next.point_total = to32(points_next);

                pos_next       = '0;
                points_next    = '0;
                expected_next  = 2'd0;
                low_next       = CONT_LO;
                high_next      = CONT_HI;
                lead_pos_next  = '0;
                pend_next      = 1'b0;
                pend_pos_next  = '0;
                err_next       = 1'b0;
                err_pos_next   = '0;
                non_ascii_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            points_reg    <= '0;
            expected_reg  <= 2'd0;
            low_reg       <= CONT_LO;
            high_reg      <= CONT_HI;
            lead_pos_reg  <= '0;
            pend_reg      <= 1'b0;
            pend_pos_reg  <= '0;
            err_reg       <= 1'b0;
            err_pos_reg   <= '0;
            non_ascii_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            points_reg    <= points_next;
            expected_reg  <= expected_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            lead_pos_reg  <= lead_pos_next;
            pend_reg      <= pend_next;
            pend_pos_reg  <= pend_pos_next;
            err_reg       <= err_next;
            err_pos_reg   <= err_pos_next;
            non_ascii_reg <= non_ascii_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS - OUT_FIELD_BITS){1'b0}}, out_reg};

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for utf8_stream_validator_unit, texts in as byte beats, one result out
// per text; a behavioral copy of the checker predicts each result. depends on utf8v_pkg
`timescale 1ns / 1ps

module tb;
    import utf8v_pkg::*;

    localparam int TARGET_BEATS = 1200;
    localparam int TAIL_BEATS   = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 20;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold;   // wait for every pending result before sending
    } text_beat_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    text_beat_t beat_q[$];
    logic [7:0] text_buf[$];
    result_t    verdicts_due[$];

    // checker state for the text in progress
    logic [31:0] byte_pos     = '0;
    logic [31:0] cp_count     = '0;
    logic [1:0]  cont_left    = '0;
    logic [7:0]  cont_lo      = CONT_LO;
    logic [7:0]  cont_hi      = CONT_HI;
    logic [31:0] lead_pos     = '0;
    logic        cont_bad     = 1'b0;
    logic [31:0] cont_bad_pos = '0;
    logic        err_seen     = 1'b0;
    logic [31:0] err_pos      = '0;
    logic        saw_high     = 1'b0;

    int mismatches    = 0;
    int bytes_sent    = 0;
    int texts_checked = 0;
    int texts_good    = 0;
    int send_gap      = 0;
    int stall_left    = 0;
    int mon_cycles    = 0;
    int cycles        = 0;
    result_t got, want;

    utf8_stream_validator_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic open_seq(input logic [1:0] need, input logic [7:0] lo, input logic [7:0] hi,
                            input logic [31:0] at);
        cont_left = need;
        cont_lo   = lo;
        cont_hi   = hi;
        lead_pos  = at;
        cont_bad  = 1'b0;
    endtask

    // advance the checker by one accepted byte; queue the verdict on the last byte
    task automatic apply_byte(input logic [7:0] b, input logic last);
        logic [31:0] here;
        result_t     fin;
        here = byte_pos;
        if (b > ASCII_MAX)
            saw_high = 1'b1;
        if (!err_seen) begin
            if (cont_left == 2'd0) begin
                if (b <= ASCII_MAX) begin
                    cp_count = sat_inc(cp_count);
                end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                    open_seq(2'd1, CONT_LO, CONT_HI, here);
                end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                    if (b == LEAD3_LO)
                        open_seq(2'd2, E0_LO, CONT_HI, here);
                    else if (b == LEAD3_SUR)
                        open_seq(2'd2, CONT_LO, ED_HI, here);
                    else
                        open_seq(2'd2, CONT_LO, CONT_HI, here);
                end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                    if (b == LEAD4_LO)
                        open_seq(2'd3, F0_LO, CONT_HI, here);
                    else if (b == LEAD4_HI)
                        open_seq(2'd3, CONT_LO, F4_HI, here);
                    else
                        open_seq(2'd3, CONT_LO, CONT_HI, here);
                end else begin
                    err_seen = 1'b1;
                    err_pos  = here;
                end
            end else begin
                // only the first bad continuation counts, and only once the sequence is full
                if (!cont_bad && (b < cont_lo || b > cont_hi)) begin
                    cont_bad     = 1'b1;
                    cont_bad_pos = here;
                end
                cont_lo   = CONT_LO;
                cont_hi   = CONT_HI;
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    if (cont_bad) begin
                        err_seen = 1'b1;
                        err_pos  = cont_bad_pos;
                        cont_bad = 1'b0;
                    end else begin
                        cp_count = sat_inc(cp_count);
                    end
                end
            end
        end
        byte_pos = sat_inc(byte_pos);
        if (last) begin
            // a cut-off sequence blames its lead byte
            if (!err_seen && cont_left != 2'd0) begin
                err_seen = 1'b1;
                err_pos  = lead_pos;
            end
            fin.text_valid  = !err_seen;
            fin.all_ascii   = !saw_high;
            fin.bad_offset  = err_seen ? err_pos : 32'd0;
            fin.point_total = cp_count;
            verdicts_due.push_back(fin);
            byte_pos     = '0;
            cp_count     = '0;
            cont_left    = '0;
            cont_lo      = CONT_LO;
            cont_hi      = CONT_HI;
            lead_pos     = '0;
            cont_bad     = 1'b0;
            cont_bad_pos = '0;
            err_seen     = 1'b0;
            err_pos      = '0;
            saw_high     = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic flush_text(input bit hold);
        text_beat_t beat;
        foreach (text_buf[i]) begin
            beat.data = text_buf[i];
            beat.last = (i == text_buf.size() - 1);
            beat.hold = hold && (i == 0);
            beat_q.push_back(beat);
        end
        text_buf.delete();
    endtask

    // append one well-formed code point with random content
    task automatic gen_code_point();
        int kind;
        int sel;
        logic [7:0] lead;
        kind = $urandom_range(0, 8);
        sel  = $urandom_range(0, 3);
        case (kind)
            0, 1, 2, 3: begin
                text_buf.push_back(8'($urandom_range(0, ASCII_MAX)));
            end
            4, 5: begin
                text_buf.push_back(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
                text_buf.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            end
            6: begin
                if (sel == 0) begin
                    text_buf.push_back(LEAD3_LO);
                    text_buf.push_back(8'($urandom_range(E0_LO, CONT_HI)));
                end else if (sel == 1) begin
                    text_buf.push_back(LEAD3_SUR);
                    text_buf.push_back(8'($urandom_range(CONT_LO, ED_HI)));
                end else begin
                    lead = 8'($urandom_range(LEAD3_LO + 1, LEAD3_HI));
                    if (lead == LEAD3_SUR)
                        lead = LEAD3_SUR + 8'd1;
                    text_buf.push_back(lead);
                    text_buf.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
                end
                text_buf.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            end
            default: begin
                if (sel == 0) begin
                    text_buf.push_back(LEAD4_LO);
                    text_buf.push_back(8'($urandom_range(F0_LO, CONT_HI)));
                end else if (sel == 1) begin
                    text_buf.push_back(LEAD4_HI);
                    text_buf.push_back(8'($urandom_range(CONT_LO, F4_HI)));
                end else begin
                    text_buf.push_back(8'($urandom_range(LEAD4_LO + 1, LEAD4_HI - 1)));
                    text_buf.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
                end
                text_buf.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
                text_buf.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            end
        endcase
    endtask

    initial begin : stimulus
        int  n_cp;
        int  flaw;
        int  idx;
        int  start;
        bit  mid_hold_done;
        mid_hold_done = 1'b0;

        // directed texts: ascii extremes, narrowed upper bounds, bad continuation,
        // cut-off sequence, bad leads with bytes after the error
        text_buf = '{8'h00, 8'h7F};
        flush_text(1'b0);
        text_buf = '{8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hED, 8'h9F, 8'h80,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF};
        flush_text(1'b0);
        text_buf = '{8'hE0, 8'h9F, 8'h80};
        flush_text(1'b0);
        text_buf = '{8'hF0, 8'h90, 8'h80};
        flush_text(1'b0);
        text_buf = '{8'hC1, 8'h41};
        flush_text(1'b0);
        text_buf = '{8'h80, 8'hFF};
        flush_text(1'b0);
        text_buf = '{8'hE0, 8'h41};
        flush_text(1'b0);

        // random texts, mostly well-formed, the rest flawed or pure noise
        while (beat_q.size() < TARGET_BEATS) begin
            flaw = $urandom_range(0, 9);
            if (flaw == 9) begin
                n_cp = $urandom_range(1, 8);
                repeat (n_cp) text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                n_cp = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
                repeat (n_cp) gen_code_point();
                if (flaw == 6) begin
                    idx = $urandom_range(0, text_buf.size() - 1);
                    text_buf[idx] = 8'($urandom_range(0, 255));
                end else if (flaw == 7) begin
                    // end the text partway through a multi-byte sequence
                    start = text_buf.size();
                    gen_code_point();
                    if (text_buf.size() - start > 1)
                        repeat ($urandom_range(1, text_buf.size() - start - 1))
                            void'(text_buf.pop_back());
                end else if (flaw == 8) begin
                    idx = $urandom_range(0, text_buf.size());
                    text_buf.insert(idx, 8'($urandom_range(CONT_LO, 255)));
                end
            end
            if (beat_q.size() == 25) begin
                flush_text(1'b1);
            end else if (!mid_hold_done && beat_q.size() >= TARGET_BEATS / 2) begin
                mid_hold_done = 1'b1;
                flush_text(1'b1);
            end else begin
                flush_text(1'b0);
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (beat_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d bytes in %0d texts: %0d well-formed, %0d rejected",
                 bytes_sent, texts_checked, texts_good, texts_checked - texts_good);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // driver: byte beats from beat_q, random idle bursts except in quiet stretches and the tail
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_byte(s_tdata, s_tlast);
                bytes_sent <= bytes_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (beat_q.size() == 0 ||
                             (beat_q[0].hold && verdicts_due.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else if (beat_q.size() > TAIL_BEATS && (bytes_sent / 150) % 3 != 2 &&
                             $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= beat_q[0].data;
                    s_tlast  <= beat_q[0].last;
                    void'(beat_q.pop_front());
                end
            end
        end
    end

    // monitor: checks each result beat against the oldest pending verdict
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            mon_cycles <= mon_cycles + 1;
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[OUT_FIELD_BITS-1:0]);
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result beat with no text pending");
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.text_valid !== want.text_valid)
                        report_mismatch($sformatf("text %0d text_valid %0b, want %0b",
                                        texts_checked, got.text_valid, want.text_valid));
                    if (got.all_ascii !== want.all_ascii)
                        report_mismatch($sformatf("text %0d all_ascii %0b, want %0b",
                                        texts_checked, got.all_ascii, want.all_ascii));
                    if (got.bad_offset !== want.bad_offset)
                        report_mismatch($sformatf("text %0d bad_offset %0d, want %0d",
                                        texts_checked, got.bad_offset, want.bad_offset));
                    if (got.point_total !== want.point_total)
                        report_mismatch($sformatf("text %0d point_total %0d, want %0d",
                                        texts_checked, got.point_total,
                                        want.point_total));
                    if (want.text_valid)
                        texts_good <= texts_good + 1;
                end
                texts_checked <= texts_checked + 1;
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (beat_q.size() > TAIL_BEATS && (mon_cycles / 200) % 4 != 3 &&
                         $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 5);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, verdicts_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
